// ----- rtl/core/bounded_sequence_list_engine_assert.svh -----
// Assertion macros shared by the list engine modules.
`ifndef BOUNDED_SEQUENCE_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_SEQUENCE_LIST_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

`define BSLE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define BSLE_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define BSLE_ASSERT(lbl, clk, rst_n, prop, msg)

`define BSLE_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ----- rtl/core/bsle_pkg.sv -----
// Types and codes shared by the list engine modules.
package bsle_pkg;

    localparam int POS_W = 6;
    localparam int LEN_W = 6;
    localparam int READ_LIMIT = 32;

    localparam logic [2:0] OP_CLEAR     = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_PUSH_BACK = 3'd2;
    localparam logic [2:0] OP_POP_FRONT = 3'd3;
    localparam logic [2:0] OP_POP_BACK  = 3'd4;
    localparam logic [2:0] OP_READ_OUT  = 3'd5;
    localparam logic [2:0] OP_INSERT_AT = 3'd6;
    localparam logic [2:0] OP_DEL_EQUAL = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_INDEX = 2'd3;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [63:0] value;
        logic [POS_W-1:0]   position;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] element;
        logic [1:0]         status;
        logic [LEN_W-1:0]   length;
        logic               has_element;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic      vld;
        t_out_item item;
    } t_emit;

endpackage

// ----- rtl/core/bsle_ram.sv -----
// Generic simple dual-port RAM with registered read.
module bsle_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/bsle_ctrl.sv -----
// Sequencer: decodes an opcode and moves entries one per cycle through the RAM.
`include "bounded_sequence_list_engine_assert.svh"

module bsle_ctrl #(
    parameter int CAPACITY = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  bsle_pkg::t_in_item          i_item,
    output logic                        o_idle,
    input  logic                        i_out_free,
    output bsle_pkg::t_emit             o_emit,
    output logic                        o_we,
    output logic [$clog2(CAPACITY)-1:0] o_waddr,
    output logic [63:0]                 o_wdata,
    output logic                        o_re,
    output logic [$clog2(CAPACITY)-1:0] o_raddr,
    input  logic [63:0]                 i_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = (CW > bsle_pkg::POS_W) ? CW : bsle_pkg::POS_W;

    typedef enum logic [2:0] {
        S_IDLE, S_SHUP, S_SHDN, S_DEL, S_READ, S_RDATA, S_EMIT
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_cnt;
    logic [AW-1:0]      r_rd;
    logic [CW-1:0]      r_wr;
    logic [AW-1:0]      r_pos;
    logic [AW-1:0]      r_lim;
    logic               r_more;
    logic               r_pend;
    logic [1:0]         r_st;
    logic signed [63:0] r_val;

    logic [WW-1:0] ins_pos;
    logic          full;
    logic          bad_idx;
    logic          append;
    logic          empty;
    logic          keep;
    logic          rd_at_end;

    always_comb begin
        case (i_item.opcode)
            bsle_pkg::OP_PUSH_FRONT: ins_pos = '0;
            bsle_pkg::OP_PUSH_BACK:  ins_pos = WW'(r_cnt);
            default:                 ins_pos = WW'(i_item.position);
        endcase
    end

    assign full      = (r_cnt >= CW'(CAPACITY));
    assign bad_idx   = (ins_pos > WW'(r_cnt));
    assign append    = (ins_pos == WW'(r_cnt));
    assign empty     = (r_cnt == '0);
    // shared compare unit: the only 64-bit comparison in the datapath
    assign keep      = (i_rdata != r_val);
    assign rd_at_end = (CW'(r_rd) == r_cnt - CW'(1));
    assign o_idle    = (r_state == S_IDLE);

    always_comb begin
        o_we    = 1'b0;
        o_waddr = r_wr[AW-1:0];
        o_wdata = r_val;
        o_re    = 1'b0;
        o_raddr = r_rd;
        o_emit  = '0;
        o_emit.item.length = bsle_pkg::LEN_W'(r_cnt);
        case (r_state)
            S_IDLE: begin
                if (i_start && !full && !bad_idx && append &&
                    (i_item.opcode == bsle_pkg::OP_PUSH_FRONT ||
                     i_item.opcode == bsle_pkg::OP_PUSH_BACK ||
                     i_item.opcode == bsle_pkg::OP_INSERT_AT)) begin
                    o_we    = 1'b1;
                    o_waddr = r_cnt[AW-1:0];
                    o_wdata = i_item.value;
                end
            end
            S_SHUP: begin
                o_re = r_more;
                if (r_pend) begin
                    o_we    = 1'b1;
                    o_wdata = i_rdata;
                end else if (!r_more) begin
                    o_we    = 1'b1;
                    o_waddr = r_pos;
                end
            end
            S_SHDN: begin
                o_re = r_more;
                if (r_pend) begin
                    o_we    = 1'b1;
                    o_wdata = i_rdata;
                end
            end
            S_DEL: begin
                o_re = r_more;
                if (r_pend && keep) begin
                    o_we    = 1'b1;
                    o_wdata = i_rdata;
                end
            end
            S_READ: begin
                o_re = i_out_free;
            end
            S_RDATA: begin
                o_emit.vld              = 1'b1;
                o_emit.item.element     = i_rdata;
                o_emit.item.status      = bsle_pkg::ST_OK;
                o_emit.item.has_element = 1'b1;
                o_emit.item.last        = (r_rd == r_lim);
            end
            S_EMIT: begin
                o_emit.vld         = i_out_free;
                o_emit.item.status = r_st;
                o_emit.item.last   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_more  <= 1'b0;
            r_pend  <= 1'b0;
            r_st    <= bsle_pkg::ST_OK;
            r_rd    <= '0;
            r_wr    <= '0;
            r_lim   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_val  <= i_item.value;
                        r_pos  <= ins_pos[AW-1:0];
                        r_st   <= bsle_pkg::ST_OK;
                        r_pend <= 1'b0;
                        r_more <= 1'b1;
                        r_state <= S_EMIT;
                        case (i_item.opcode)
                            bsle_pkg::OP_CLEAR: begin
                                r_cnt <= '0;
                            end
                            bsle_pkg::OP_PUSH_FRONT, bsle_pkg::OP_PUSH_BACK,
                            bsle_pkg::OP_INSERT_AT: begin
                                if (full) begin
                                    r_st <= bsle_pkg::ST_FULL;
                                end else if (bad_idx) begin
                                    r_st <= bsle_pkg::ST_INDEX;
                                end else if (append) begin
                                    r_cnt <= r_cnt + CW'(1);
                                end else begin
                                    r_rd    <= AW'(r_cnt - CW'(1));
                                    r_wr    <= r_cnt;
                                    r_state <= S_SHUP;
                                end
                            end
                            bsle_pkg::OP_POP_FRONT: begin
                                if (empty) begin
                                    r_st <= bsle_pkg::ST_EMPTY;
                                end else if (r_cnt == CW'(1)) begin
                                    r_cnt <= '0;
                                end else begin
                                    r_rd    <= AW'(1);
                                    r_wr    <= '0;
                                    r_state <= S_SHDN;
                                end
                            end
                            bsle_pkg::OP_POP_BACK: begin
                                if (empty) begin
                                    r_st <= bsle_pkg::ST_EMPTY;
                                end else begin
                                    r_cnt <= r_cnt - CW'(1);
                                end
                            end
                            bsle_pkg::OP_READ_OUT: begin
                                if (empty) begin
                                    r_st <= bsle_pkg::ST_EMPTY;
                                end else begin
                                    r_rd <= '0;
                                    if (WW'(r_cnt) > WW'(bsle_pkg::READ_LIMIT)) begin
                                        r_lim <= AW'(bsle_pkg::READ_LIMIT - 1);
                                    end else begin
                                        r_lim <= AW'(r_cnt - CW'(1));
                                    end
                                    r_state <= S_READ;
                                end
                            end
                            default: begin
                                // delete every entry equal to the value
                                if (empty) begin
                                    r_st <= bsle_pkg::ST_EMPTY;
                                end else begin
                                    r_rd    <= '0;
                                    r_wr    <= '0;
                                    r_state <= S_DEL;
                                end
                            end
                        endcase
                    end
                end
                S_SHUP: begin
                    // reads walk down from the back; writes trail one slot above
                    if (r_more) begin
                        if (r_rd == r_pos) begin
                            r_more <= 1'b0;
                        end else begin
                            r_rd <= r_rd - AW'(1);
                        end
                    end
                    r_pend <= r_more;
                    if (r_pend) begin
                        r_wr <= r_wr - CW'(1);
                    end
                    if (!r_more && !r_pend) begin
                        r_cnt   <= r_cnt + CW'(1);
                        r_state <= S_EMIT;
                    end
                end
                S_SHDN: begin
                    if (r_more) begin
                        if (rd_at_end) begin
                            r_more <= 1'b0;
                        end else begin
                            r_rd <= r_rd + AW'(1);
                        end
                    end
                    r_pend <= r_more;
                    if (r_pend) begin
                        r_wr <= r_wr + CW'(1);
                    end
                    if (!r_more && !r_pend) begin
                        r_cnt   <= r_cnt - CW'(1);
                        r_state <= S_EMIT;
                    end
                end
                S_DEL: begin
                    if (r_more) begin
                        if (rd_at_end) begin
                            r_more <= 1'b0;
                        end else begin
                            r_rd <= r_rd + AW'(1);
                        end
                    end
                    r_pend <= r_more;
                    if (r_pend && keep) begin
                        r_wr <= r_wr + CW'(1);
                    end
                    if (!r_more && !r_pend) begin
                        r_cnt   <= r_wr;
                        r_state <= S_EMIT;
                    end
                end
                S_READ: begin
                    if (i_out_free) begin
                        r_state <= S_RDATA;
                    end
                end
                S_RDATA: begin
                    if (r_rd == r_lim) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_rd    <= r_rd + AW'(1);
                        r_state <= S_READ;
                    end
                end
                S_EMIT: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `BSLE_NEVER(a_cnt_bound, i_clk, i_rst_n, r_cnt > CW'(CAPACITY), "entry count above capacity")
    `BSLE_ASSERT(a_emit_free, i_clk, i_rst_n, o_emit.vld |-> i_out_free, "result with output busy")
    `BSLE_ASSERT(a_waddr, i_clk, i_rst_n, o_we |-> (CW'(o_waddr) < CW'(CAPACITY)), "write out of range")
    `BSLE_ASSERT(a_pend_read, i_clk, i_rst_n, r_pend |-> $past(o_re), "pending data without a read")

endmodule

// ----- rtl/core/bounded_sequence_list_engine.sv -----
// Top level: ordered list engine with entry RAM, sequencer and output register.
//
// Bounded ordered list of up to CAPACITY signed 64-bit entries kept in a
// simple dual-port RAM, one opcode per input transfer. The input is taken
// only when the sequencer is idle; the output register lets the next opcode
// in while a result still waits. Clear, pop-back, push-back, an append-point
// insert, a pop-front of a single entry and every refused operation go from
// idle straight to S_EMIT, which loads the status result. Push-front,
// pop-front, insert-at and delete-equal move one entry per cycle through the
// RAM and then go to S_EMIT; the next transfer is taken once the sequencer is
// back in idle. A read-out gives its elements in order, each through S_READ
// and S_RDATA (registered RAM read), up to 32 elements. A result that the
// receiver does not take stalls the sequencer in place. The RAM needs no
// clearing pass after reset.
module bounded_sequence_list_engine #(
    parameter int CAPACITY = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bsle_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bsle_pkg::t_out_item  o_out_item
);

    localparam int AW = $clog2(CAPACITY);

    logic                r_out_valid;
    bsle_pkg::t_out_item r_out_item;
    logic                out_free;
    logic                start;
    bsle_pkg::t_emit     emit;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [63:0]         wdata;
    logic                re;
    logic [AW-1:0]       raddr;
    logic [63:0]         rdata;

    assign out_free = !r_out_valid || i_out_ready;
    assign start    = i_in_valid && o_in_ready;

    bsle_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (i_in_item),
        .o_idle     (o_in_ready),
        .i_out_free (out_free),
        .o_emit     (emit),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_re       (re),
        .o_raddr    (raddr),
        .i_rdata    (rdata)
    );

    bsle_ram #(
        .WIDTH (64),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // result register: loaded only when empty or being drained this cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.vld) begin
            r_out_valid <= 1'b1;
            r_out_item  <= emit.item;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
